FILE: rtl/core/pcmt_pkg.sv
// Shared types and constants of the proxy client mapping table.
package pcmt_pkg;

  // Table size and the widths derived from it.
  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned ID_W     = 9;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FUNC_W   = 2;

  // Reset value of the base proxy port register.
  localparam logic [PORT_W-1:0] BASE_PORT_RST = PORT_W'(12345);

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP_SRC   = 2'd0,
    FUNC_LOOKUP_PROXY = 2'd1,
    FUNC_ADD          = 2'd2,
    FUNC_REMOVE       = 2'd3
  } func_e;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // Search token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              tgt_ok;
    logic [IDX_W-1:0]  tgt_idx;
    logic              tgt_used;
    logic [ADDR_W-1:0] hit_addr;
    logic [PORT_W-1:0] hit_port;
    logic              match_found;
    logic [IDX_W-1:0]  match_idx;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } token_t;

  // Slot update broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic              set;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } slot_wr_t;

endpackage

FILE: rtl/core/pcmt_cell.sv
// One table slot: holds a client key and inspects the passing search token.
module pcmt_cell
  import pcmt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  slot_wr_t         wr_i,
  input  token_t           tok_i,
  output token_t           tok_o
);

  logic              used_q, used_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PORT_W-1:0] port_q, port_d;
  logic              tok_vld_q;
  token_t            tok_d, tok_q;
  logic              wr_hit;
  logic              key_match;

  // Slot update from the controller.
  assign wr_hit = wr_i.en && (wr_i.idx == cell_idx_i);

  always_comb begin
    used_d = used_q;
    addr_d = addr_q;
    port_d = port_q;
    if (wr_hit) begin
      used_d = wr_i.set;
      if (wr_i.set) begin
        addr_d = wr_i.addr;
        port_d = wr_i.port;
      end
    end
  end

  // Update the token with what this slot contributes.
  assign key_match = used_q && (addr_q == tok_i.addr) && (port_q == tok_i.port);

  always_comb begin
    tok_d = tok_i;
    if (key_match && !tok_i.match_found) begin
      tok_d.match_found = 1'b1;
      tok_d.match_idx   = cell_idx_i;
    end
    if (!used_q && !tok_i.free_found) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = cell_idx_i;
    end
    if (tok_i.tgt_ok && (tok_i.tgt_idx == cell_idx_i)) begin
      tok_d.tgt_used = used_q;
      tok_d.hit_addr = addr_q;
      tok_d.hit_port = port_q;
    end
  end

  // Used flag and token valid are control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      used_q    <= used_d;
      tok_vld_q <= tok_i.valid;
    end
  end

  // Stored key and token payload.
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    port_q <= port_d;
    tok_q  <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_vld_q;
  end

endmodule

FILE: rtl/core/proxy_client_map_table.sv
// Top level of the proxy client mapping table: controller and row of slot cells.
//
//  Channel  Handshake                 Word
//  in       in_valid_i / in_ready_o   func_i, src_addr_i, src_port_i, proxy_port_i, entry_id_i
//  out      out_valid_o / out_ready_i status_o, result_id_o, found_addr_o, found_port_o
//  cfg      cfg_valid_i / cfg_ready_o cfg_data_i (base proxy port)
//
// Each word is handled in steps: a search token walks the row of cells, one slot per
// cycle, the search summary is registered, and the result and any slot update are
// then registered together once the output register is free.
// Reset empties the table at once and sets the base port to 12345.
// A new word is taken only while no word is in progress; a finished result waits
// in the output register, and the controller holds while that register is full.
module proxy_client_map_table
  import pcmt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [ADDR_W-1:0]   src_addr_i,
  input  logic [PORT_W-1:0]   src_port_i,
  input  logic [PORT_W-1:0]   proxy_port_i,
  input  logic [ID_W-1:0]     entry_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     result_id_o,
  output logic [ADDR_W-1:0]   found_addr_o,
  output logic [PORT_W-1:0]   found_port_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [PORT_W-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [PORT_W-1:0]   base_q;
  func_e               func_q;
  logic                zero_key_q;
  token_t              sum_q;
  token_t              tok_head;
  token_t              chain [ENTRIES+1];
  logic [ENTRIES-1:0]  tok_vld;
  slot_wr_t            wr;
  logic                in_fire;
  logic                fin_go;
  logic [PORT_W:0]     pdiff;
  logic [ID_W-1:0]     rid_m1;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_d, status_q;
  logic [ID_W-1:0]     rid_d, rid_q;
  logic [ADDR_W-1:0]   faddr_d, faddr_q;
  logic [PORT_W-1:0]   fport_d, fport_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Target slot for lookup by proxy port and for remove.
  assign pdiff  = {1'b0, proxy_port_i} - {1'b0, base_q};
  assign rid_m1 = entry_id_i - ID_W'(1);

  always_comb begin
    tok_head             = '0;
    tok_head.valid       = in_fire;
    tok_head.addr        = src_addr_i;
    tok_head.port        = src_port_i;
    if (func_e'(func_i) == FUNC_LOOKUP_PROXY) begin
      tok_head.tgt_ok  = !pdiff[PORT_W] && (32'(pdiff[PORT_W-1:0]) < 32'(ENTRIES));
      tok_head.tgt_idx = IDX_W'(pdiff[PORT_W-1:0]);
    end else begin
      tok_head.tgt_ok  = (entry_id_i != '0) && (32'(entry_id_i) <= 32'(ENTRIES));
      tok_head.tgt_idx = IDX_W'(rid_m1);
    end
  end

  assign chain[0] = tok_head;

  // Row of slot cells.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pcmt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .wr_i       (wr),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
    assign tok_vld[g] = chain[g+1].valid;
  end

  // Result decision once the token has passed every slot.
  assign fin_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    status_d = ST_NOT_FOUND;
    rid_d    = '0;
    faddr_d  = '0;
    fport_d  = '0;
    wr       = '0;
    wr.idx   = sum_q.tgt_idx;
    wr.addr  = sum_q.addr;
    wr.port  = sum_q.port;
    unique case (func_q)
      FUNC_LOOKUP_SRC: begin
        if (sum_q.match_found) begin
          status_d = ST_OK;
          rid_d    = ID_W'({1'b0, sum_q.match_idx} + 1'b1);
        end
      end
      FUNC_LOOKUP_PROXY: begin
        if (sum_q.tgt_ok && sum_q.tgt_used) begin
          status_d = ST_OK;
          rid_d    = ID_W'({1'b0, sum_q.tgt_idx} + 1'b1);
          faddr_d  = sum_q.hit_addr;
          fport_d  = sum_q.hit_port;
        end
      end
      FUNC_ADD: begin
        if (zero_key_q) begin
          status_d = ST_ZERO_KEY;
        end else if (sum_q.match_found) begin
          status_d = ST_DUPLICATE;
          rid_d    = ID_W'({1'b0, sum_q.match_idx} + 1'b1);
        end else if (!sum_q.free_found) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          rid_d    = ID_W'({1'b0, sum_q.free_idx} + 1'b1);
          wr.en    = fin_go;
          wr.set   = 1'b1;
          wr.idx   = sum_q.free_idx;
        end
      end
      FUNC_REMOVE: begin
        if (sum_q.tgt_ok && sum_q.tgt_used) begin
          status_d = ST_OK;
          rid_d    = ID_W'({1'b0, sum_q.tgt_idx} + 1'b1);
          wr.en    = fin_go;
          wr.set   = 1'b0;
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[ENTRIES].valid) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= BASE_PORT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, search summary and result registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q     <= func_e'(func_i);
      zero_key_q <= (src_addr_i == '0) || (src_port_i == '0);
    end
    if ((state_q == ST_SCAN) && chain[ENTRIES].valid) begin
      sum_q <= chain[ENTRIES];
    end
    if (fin_go) begin
      status_q <= status_d;
      rid_q    <= rid_d;
      faddr_q  <= faddr_d;
      fport_q  <= fport_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign result_id_o  = rid_q;
  assign found_addr_o = faddr_q;
  assign found_port_o = fport_q;

  // At most one search token is in the row.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one search token in the cell row");

  // The token leaves the row only while the sequencer waits for it.
  a_tok_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[ENTRIES].valid |-> (state_q == ST_SCAN))
    else $error("search token finished outside of the scan");

  // Slots change only when a result is issued.
  a_wr_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> fin_go)
    else $error("slot update without a result");

  // An issued result is presented on the next cycle.
  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o)
    else $error("result not presented after finish");

endmodule
